// ----- design/kts_pkg.sv -----
// shared widths and types for the key/tag sorter
package kts_pkg;

    localparam int KTS_MAX_ITEMS = 64;
    localparam int KEY_W         = 64;
    localparam int TAG_W         = 32;
    localparam int ENTRY_W       = KEY_W + TAG_W;

    // sort launch command from the load side to the selection engine
    typedef struct packed {
        logic start;
        logic dropped;
    } kts_cmd_t;

endpackage

// ----- design/kts_mem.sv -----
// pair store: one write port, one read port with registered read data
module kts_mem #(
    parameter int DEPTH  = kts_pkg::KTS_MAX_ITEMS,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic                        clk,
    input  logic                        wr_en,
    input  logic [ADDR_W-1:0]           wr_addr,
    input  logic [kts_pkg::ENTRY_W-1:0] wr_data,
    input  logic                        rd_en,
    input  logic [ADDR_W-1:0]           rd_addr,
    output logic [kts_pkg::ENTRY_W-1:0] rd_data
);
    import kts_pkg::*;

    logic [ENTRY_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- design/kts_sel.sv -----
// selection engine: one memory scan per result, picks next (key, index) in order
module kts_sel #(
    parameter int MAX_ITEMS = kts_pkg::KTS_MAX_ITEMS,
    parameter int IDX_W     = $clog2(MAX_ITEMS),
    parameter int CNT_W     = $clog2(MAX_ITEMS + 1)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  kts_pkg::kts_cmd_t           cmd,
    input  logic [CNT_W-1:0]            cnt,
    output logic                        rd_en,
    output logic [IDX_W-1:0]            rd_addr,
    input  logic [kts_pkg::ENTRY_W-1:0] rd_data,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [kts_pkg::KEY_W-1:0]   sorted_key,
    output logic [kts_pkg::TAG_W-1:0]   sorted_tag,
    output logic                        end_of_set,
    output logic                        overflow,
    output logic                        done
);
    import kts_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMIT
    } state_t;

    state_t             state_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   rank_reg;
    logic [CNT_W-1:0]   addr_reg;
    logic               drop_reg;
    logic               pend_reg;
    logic [IDX_W-1:0]   pend_idx_reg;
    logic               have_prev_reg;
    logic [KEY_W-1:0]   prev_key_reg;
    logic [IDX_W-1:0]   prev_idx_reg;
    logic               best_found_reg;
    logic [KEY_W-1:0]   best_key_reg;
    logic [IDX_W-1:0]   best_idx_reg;
    logic [TAG_W-1:0]   best_tag_reg;

    logic [KEY_W-1:0]       rd_key;
    logic [TAG_W-1:0]       rd_tag;
    logic [KEY_W+IDX_W-1:0] cand_ord;
    logic                   above_prev;
    logic                   below_best;
    logic                   cand_ok;
    logic                   is_last;

    assign rd_key = rd_data[ENTRY_W-1:TAG_W];
    assign rd_tag = rd_data[TAG_W-1:0];

    // index breaks ties so that equal keys leave in load order
    assign cand_ord   = {rd_key, pend_idx_reg};
    assign above_prev = !have_prev_reg || (cand_ord > {prev_key_reg, prev_idx_reg});
    assign below_best = !best_found_reg || (cand_ord < {best_key_reg, best_idx_reg});
    assign cand_ok    = pend_reg && above_prev && below_best;

    assign rd_en   = (state_reg == ST_SCAN) && (addr_reg < cnt_reg);
    assign rd_addr = addr_reg[IDX_W-1:0];
    assign is_last = (rank_reg + CNT_W'(1)) == cnt_reg;

    assign out_valid  = (state_reg == ST_EMIT);
    assign sorted_key = best_key_reg;
    assign sorted_tag = best_tag_reg;
    assign end_of_set = is_last;
    assign overflow   = drop_reg;
    assign done       = (state_reg == ST_EMIT) && !out_stall && is_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            rank_reg       <= '0;
            addr_reg       <= '0;
            drop_reg       <= 1'b0;
            pend_reg       <= 1'b0;
            have_prev_reg  <= 1'b0;
            best_found_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (cmd.start)
                    begin
                        cnt_reg        <= cnt;
                        drop_reg       <= cmd.dropped;
                        rank_reg       <= '0;
                        addr_reg       <= '0;
                        pend_reg       <= 1'b0;
                        have_prev_reg  <= 1'b0;
                        best_found_reg <= 1'b0;
                        state_reg      <= ST_SCAN;
                    end
                end
                ST_SCAN:
                begin
                    pend_reg     <= rd_en;
                    pend_idx_reg <= addr_reg[IDX_W-1:0];
                    if (rd_en)
                    begin
                        addr_reg <= addr_reg + CNT_W'(1);
                    end
                    if (cand_ok)
                    begin
                        best_found_reg <= 1'b1;
                        best_key_reg   <= rd_key;
                        best_idx_reg   <= pend_idx_reg;
                        best_tag_reg   <= rd_tag;
                    end
                    // scan complete once nothing issued and nothing in flight
                    if (!rd_en && !pend_reg)
                    begin
                        state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT:
                begin
                    if (!out_stall)
                    begin
                        prev_key_reg   <= best_key_reg;
                        prev_idx_reg   <= best_idx_reg;
                        have_prev_reg  <= 1'b1;
                        best_found_reg <= 1'b0;
                        addr_reg       <= '0;
                        rank_reg       <= rank_reg + CNT_W'(1);
                        state_reg      <= is_last ? ST_IDLE : ST_SCAN;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- design/key_tag_sorter_top.sv -----
// key/tag sorter top: load side, fill count, pair store and selection engine
// load: one pair per cycle, no stall while filling a set
// sort: after the last transaction each result takes one full memory scan over
//   the single read port, and a result can be held by out_stall
// input stall stays high from the last transaction until the final result is taken
// reset clears fill count, drop flag and control; store contents are not cleared
module key_tag_sorter_top #(
    parameter int MAX_ITEMS = kts_pkg::KTS_MAX_ITEMS
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [kts_pkg::KEY_W-1:0] key,
    input  logic [kts_pkg::TAG_W-1:0] tag,
    input  logic                      last,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [kts_pkg::KEY_W-1:0] sorted_key,
    output logic [kts_pkg::TAG_W-1:0] sorted_tag,
    output logic                      end_of_set,
    output logic                      overflow
);
    import kts_pkg::*;

    localparam int IDX_W = $clog2(MAX_ITEMS);
    localparam int CNT_W = $clog2(MAX_ITEMS + 1);

    logic [CNT_W-1:0]   fill_count_reg;
    logic [CNT_W-1:0]   fill_count_next;
    logic               dropped_reg;
    logic               dropped_next;
    logic               busy_reg;
    logic               busy_next;

    logic               in_acc;
    logic               full;
    logic               wr_en;
    logic [CNT_W-1:0]   fill_inc;
    logic               drop_upd;
    kts_cmd_t           cmd;
    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;
    logic [ENTRY_W-1:0] rd_data;
    logic               done;

    assign in_stall = busy_reg;
    assign in_acc   = in_valid && !busy_reg;
    assign full     = (fill_count_reg == CNT_W'(MAX_ITEMS));
    assign wr_en    = in_acc && !full;
    assign fill_inc = wr_en ? (fill_count_reg + CNT_W'(1)) : fill_count_reg;
    assign drop_upd = dropped_reg || (in_acc && full);

    assign cmd.start   = in_acc && last;
    assign cmd.dropped = drop_upd;

    always_comb
    begin
        fill_count_next = fill_count_reg;
        dropped_next    = dropped_reg;
        busy_next       = busy_reg;
        if (in_acc)
        begin
            if (last)
            begin
                fill_count_next = '0;
                dropped_next    = 1'b0;
                busy_next       = 1'b1;
            end
            else
            begin
                fill_count_next = fill_inc;
                dropped_next    = drop_upd;
            end
        end
        if (done)
        begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_count_reg <= '0;
            dropped_reg    <= 1'b0;
            busy_reg       <= 1'b0;
        end
        else
        begin
            fill_count_reg <= fill_count_next;
            dropped_reg    <= dropped_next;
            busy_reg       <= busy_next;
        end
    end

    kts_mem #(
        .DEPTH  (MAX_ITEMS),
        .ADDR_W (IDX_W)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (fill_count_reg[IDX_W-1:0]),
        .wr_data ({key, tag}),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    kts_sel #(
        .MAX_ITEMS (MAX_ITEMS),
        .IDX_W     (IDX_W),
        .CNT_W     (CNT_W)
    ) u_sel (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .cnt        (fill_inc),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .sorted_key (sorted_key),
        .sorted_tag (sorted_tag),
        .end_of_set (end_of_set),
        .overflow   (overflow),
        .done       (done)
    );

    // results only appear while a set is being sorted
    a_out_in_sort: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> busy_reg)
        else $error("result transaction outside a sort");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_count_reg <= CNT_W'(MAX_ITEMS))
        else $error("fill count beyond capacity");

    a_end_frees: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && end_of_set) |=> !busy_reg)
        else $error("sorter still busy after final result");

    a_sort_start: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy_reg) |-> $past(in_valid && last && fill_count_next == '0))
        else $error("sort started without a last transaction");

endmodule

// ----- bench/tb.sv -----
// testbench for key_tag_sorter_top: stable sort of key/tag sets checked against a local model
module tb;
    import kts_pkg::*;

    localparam int DEPTH = KTS_MAX_ITEMS;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [TAG_W-1:0] tag;
        logic             eos;
        logic             ovf;
    } sorted_pair_t;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [TAG_W-1:0] tag;
        logic             last;
        bit               typed;
        sorted_pair_t     want;
    } load_row_t;

    logic             clk;
    logic             rst_n;
    logic             in_valid;
    logic             in_stall;
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
    logic             last;
    logic             out_valid;
    logic             out_stall;
    logic [KEY_W-1:0] sorted_key;
    logic [TAG_W-1:0] sorted_tag;
    logic             end_of_set;
    logic             overflow;

    // model of the pair store
    logic [KEY_W-1:0] key_mem [DEPTH];
    logic [TAG_W-1:0] tag_mem [DEPTH];
    int               fill_cnt;
    bit               dropped;

    sorted_pair_t     pending_pairs [$];
    load_row_t        load_rows [$];
    int               mismatches;
    int               sender_idle_pct;
    int               recv_stall_pct;
    int               hold_left;

    key_tag_sorter_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .key        (key),
        .tag        (tag),
        .last       (last),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .sorted_key (sorted_key),
        .sorted_tag (sorted_tag),
        .end_of_set (end_of_set),
        .overflow   (overflow)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #4000000;
        $display("FAILURE");
        $finish;
    end

    // stores one pair and, on the closing pair, returns the stable sorted run
    function automatic void load_and_sort(input logic [KEY_W-1:0] k, input logic [TAG_W-1:0] t,
                                          input logic l, ref sorted_pair_t run_q[$]);
        logic [KEY_W-1:0] run_key [DEPTH];
        logic [TAG_W-1:0] run_tag [DEPTH];
        logic [KEY_W-1:0] hold_key;
        logic [TAG_W-1:0] hold_tag;
        sorted_pair_t     p;
        int               j;
        run_q.delete();
        if (fill_cnt < DEPTH)
        begin
            key_mem[fill_cnt] = k;
            tag_mem[fill_cnt] = t;
            fill_cnt++;
        end
        else
            dropped = 1'b1;
        if (!l)
            return;
        for (int i = 0; i < fill_cnt; i++)
        begin
            run_key[i] = key_mem[i];
            run_tag[i] = tag_mem[i];
        end
        // insertion sort, strict compare keeps equal keys in load order
        for (int i = 1; i < fill_cnt; i++)
        begin
            hold_key = run_key[i];
            hold_tag = run_tag[i];
            j = i;
            while (j > 0 && run_key[j-1] > hold_key)
            begin
                run_key[j] = run_key[j-1];
                run_tag[j] = run_tag[j-1];
                j--;
            end
            run_key[j] = hold_key;
            run_tag[j] = hold_tag;
        end
        for (int i = 0; i < fill_cnt; i++)
        begin
            p.key = run_key[i];
            p.tag = run_tag[i];
            p.eos = (i == fill_cnt - 1);
            p.ovf = dropped;
            run_q.push_back(p);
        end
        fill_cnt = 0;
        dropped  = 1'b0;
    endfunction

    function automatic logic [KEY_W-1:0] pick_key();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            2, 3, 4: return KEY_W'($urandom_range(7));   // many duplicates to test stability
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // entered and left at a falling edge; valid stays high if the next call follows at once
    task automatic send_pair(input logic [KEY_W-1:0] k, input logic [TAG_W-1:0] t,
                             input logic l, input bit typed, input sorted_pair_t want);
        sorted_pair_t run_q [$];
        while ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        key      <= k;
        tag      <= t;
        last     <= l;
        @(posedge clk);
        while (in_stall !== 1'b0)
            @(posedge clk);
        load_and_sort(k, t, l, run_q);
        if (typed)
            pending_pairs.push_back(want);
        else
            foreach (run_q[i])
                pending_pairs.push_back(run_q[i]);
        @(negedge clk);
    endtask

    task automatic send_set(input int n);
        for (int i = 0; i < n; i++)
            send_pair(pick_key(), $urandom, i == n - 1, 1'b0, '0);
    endtask

    task automatic send_small_sets(input int n);
        int sent;
        int sz;
        sent = 0;
        while (sent < n)
        begin
            sz = $urandom_range(1, 12);
            send_set(sz);
            sent += sz;
        end
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        wait (pending_pairs.size() == 0);
        @(negedge clk);
    endtask

    task automatic add_row(input logic [KEY_W-1:0] k, input logic [TAG_W-1:0] t, input logic l,
                           input bit typed, input logic [KEY_W-1:0] wk,
                           input logic [TAG_W-1:0] wt, input logic weos, input logic wovf);
        load_row_t r;
        r.key  = k;
        r.tag  = t;
        r.last = l;
        r.typed = typed;
        r.want = '{key: wk, tag: wt, eos: weos, ovf: wovf};
        load_rows.push_back(r);
    endtask

    // receiver: random stall, plus a counted hold-off when requested
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin : check_out
        sorted_pair_t want;
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            if (pending_pairs.size() == 0)
            begin
                $error("unexpected transaction: key %h tag %h", sorted_key, sorted_tag);
                mismatches++;
            end
            else
            begin
                want = pending_pairs.pop_front();
                if (sorted_key !== want.key)
                begin
                    $error("sorted_key: expected %h, got %h", want.key, sorted_key);
                    mismatches++;
                end
                if (sorted_tag !== want.tag)
                begin
                    $error("sorted_tag: expected %h, got %h", want.tag, sorted_tag);
                    mismatches++;
                end
                if (end_of_set !== want.eos)
                begin
                    $error("end_of_set: expected %b, got %b", want.eos, end_of_set);
                    mismatches++;
                end
                if (overflow !== want.ovf)
                begin
                    $error("overflow: expected %b, got %b", want.ovf, overflow);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        rst_n           = 1'b0;
        in_valid        = 1'b0;
        key             = '0;
        tag             = '0;
        last            = 1'b0;
        fill_cnt        = 0;
        dropped         = 1'b0;
        mismatches      = 0;
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        hold_left       = 0;

        // single-pair sets: the result is the pair itself
        add_row('0, '0, 1'b1, 1'b1, '0, '0, 1'b1, 1'b0);
        add_row('1, '1, 1'b1, 1'b1, '1, '1, 1'b1, 1'b0);
        add_row(64'h8000_0000_0000_0000, 32'h8000_0000, 1'b1, 1'b1,
                64'h8000_0000_0000_0000, 32'h8000_0000, 1'b1, 1'b0);
        add_row(64'h5555_5555_5555_5555, 32'haaaa_aaaa, 1'b1, 1'b1,
                64'h5555_5555_5555_5555, 32'haaaa_aaaa, 1'b1, 1'b0);
        add_row(64'haaaa_aaaa_aaaa_aaaa, 32'h5555_5555, 1'b1, 1'b1,
                64'haaaa_aaaa_aaaa_aaaa, 32'h5555_5555, 1'b1, 1'b0);
        // reversed pair
        add_row('1, 32'd1, 1'b0, 1'b0, '0, '0, 1'b0, 1'b0);
        add_row('0, 32'd2, 1'b1, 1'b0, '0, '0, 1'b0, 1'b0);
        // interleaved equal keys
        add_row(64'd5, 32'd10, 1'b0, 1'b0, '0, '0, 1'b0, 1'b0);
        add_row(64'd3, 32'd11, 1'b0, 1'b0, '0, '0, 1'b0, 1'b0);
        add_row(64'd5, 32'd12, 1'b0, 1'b0, '0, '0, 1'b0, 1'b0);
        add_row(64'd3, 32'd13, 1'b0, 1'b0, '0, '0, 1'b0, 1'b0);
        add_row(64'd5, 32'd14, 1'b1, 1'b0, '0, '0, 1'b0, 1'b0);
        // already ascending
        add_row(64'd1, 32'd1, 1'b0, 1'b0, '0, '0, 1'b0, 1'b0);
        add_row(64'd2, 32'd2, 1'b0, 1'b0, '0, '0, 1'b0, 1'b0);
        add_row(64'd3, 32'd3, 1'b1, 1'b0, '0, '0, 1'b0, 1'b0);
        // top bit must compare unsigned
        add_row(64'h8000_0000_0000_0000, 32'd1, 1'b0, 1'b0, '0, '0, 1'b0, 1'b0);
        add_row(64'h7fff_ffff_ffff_ffff, 32'd2, 1'b0, 1'b0, '0, '0, 1'b0, 1'b0);
        add_row('0, 32'd3, 1'b0, 1'b0, '0, '0, 1'b0, 1'b0);
        add_row('1, 32'd4, 1'b1, 1'b0, '0, '0, 1'b0, 1'b0);
        // all keys equal at the maximum
        add_row('1, 32'd1, 1'b0, 1'b0, '0, '0, 1'b0, 1'b0);
        add_row('1, 32'd2, 1'b0, 1'b0, '0, '0, 1'b0, 1'b0);
        add_row('1, 32'd3, 1'b1, 1'b0, '0, '0, 1'b0, 1'b0);

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (load_rows[i])
            send_pair(load_rows[i].key, load_rows[i].tag, load_rows[i].last,
                      load_rows[i].typed, load_rows[i].want);

        // no idling, then a long receiver hold-off while two sets keep coming
        send_small_sets(6);
        hold_left = 500;
        send_set(6);
        send_set(6);
        wait_drained();

        // sender mostly idle, one exactly full set
        sender_idle_pct = 88;
        recv_stall_pct  = 0;
        send_small_sets(6);
        send_set(DEPTH);

        // receiver mostly stalling, overflow where the closing pair and the one before it are dropped
        sender_idle_pct = 0;
        recv_stall_pct  = 88;
        send_small_sets(6);
        send_set(DEPTH + 2);

        // both idling, overflow where only the closing pair is dropped
        sender_idle_pct = 35;
        recv_stall_pct  = 35;
        send_small_sets(6);
        send_set(DEPTH + 1);

        wait_drained();
        repeat (150) @(posedge clk);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
